### hdl/ibwp_pkg.sv
// ----------------------------------------------------------------------------
// Interleaved bitplane word packer: shared definitions
// Widths, register indexes, reset values and the group hand-off type that
// passes from the pixel gatherer to the word emitter.
// ----------------------------------------------------------------------------
package ibwp_pkg;

    localparam int MAX_PLANES = 8;
    localparam int WORD_BITS  = 16;
    localparam int PIX_W      = 8;
    localparam int DIM_W      = 16;
    localparam int PCNT_W     = 4;
    localparam int IDX_W      = 3;
    localparam int POS_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT  = 2'd2;

    // Register values after reset.
    localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH  = 16'd320;
    localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT = 16'd200;
    localparam logic [PCNT_W-1:0] RST_PLANE_COUNT  = 4'd4;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [MAX_PLANES-1:0][WORD_BITS-1:0] plane_words_t;

    // Live configuration seen by the gatherer.
    typedef struct packed {
        logic [DIM_W-1:0]  image_width;
        logic [DIM_W-1:0]  image_height;
        logic [PCNT_W-1:0] plane_count;
    } cfg_t;

    // One finished group, padded and ready to be sent out.
    typedef struct packed {
        logic              valid;
        plane_words_t      words;
        logic [PCNT_W-1:0] planes;
        logic              image_end;
    } grp_load_t;

endpackage

### hdl/ibwp_pixel_if.sv
// ----------------------------------------------------------------------------
// Pixel channel
// Valid/ready channel carrying one chunky pixel per word.
// ----------------------------------------------------------------------------
interface ibwp_pixel_if
    import ibwp_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

### hdl/ibwp_word_if.sv
// ----------------------------------------------------------------------------
// Plane word channel
// Valid/ready channel carrying one 16-bit plane word with its markers.
// ----------------------------------------------------------------------------
interface ibwp_word_if
    import ibwp_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [WORD_BITS-1:0] plane_word;
    logic [IDX_W-1:0] plane_index;
    logic             group_last;
    logic             image_last;

    modport source (output valid, output plane_word, output plane_index,
                    output group_last, output image_last, input ready);
    modport sink   (input valid, input plane_word, input plane_index,
                    input group_last, input image_last, output ready);
endinterface

### hdl/ibwp_gather.sv
// ----------------------------------------------------------------------------
// Pixel gatherer
// Shifts each pixel's bits into the plane registers, keeps the column and
// row counters, and hands a padded group to the emitter at each group end.
// ----------------------------------------------------------------------------
module ibwp_gather
    import ibwp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    ibwp_pixel_if.sink        pixels,
    input  logic              load_ok,
    output grp_load_t         grp
);

    plane_words_t      shift_reg;
    plane_words_t      shift_next;
    logic [DIM_W-1:0]  col_reg;
    logic [DIM_W-1:0]  row_reg;
    logic [PCNT_W-1:0] planes_eff;
    logic [DIM_W-1:0]  width_eff;
    logic [DIM_W-1:0]  height_eff;
    logic              row_end;
    logic              img_end;
    logic              group_end;
    logic [POS_W-1:0]  pad;
    logic              accept;

    // Clamp the registers to their usable ranges.
    always_comb
    begin
        if (cfg.plane_count == '0)
        begin
            planes_eff = PCNT_W'(1);
        end
        else if (cfg.plane_count > PCNT_W'(MAX_PLANES))
        begin
            planes_eff = PCNT_W'(MAX_PLANES);
        end
        else
        begin
            planes_eff = cfg.plane_count;
        end
        width_eff  = (cfg.image_width  == '0) ? DIM_W'(1) : cfg.image_width;
        height_eff = (cfg.image_height == '0) ? DIM_W'(1) : cfg.image_height;
    end

    // Position of this pixel within the row, group and image.
    assign row_end   = ({1'b0, col_reg} + (DIM_W+1)'(1)) >= {1'b0, width_eff};
    assign img_end   = row_end &&
                       (({1'b0, row_reg} + (DIM_W+1)'(1)) >= {1'b0, height_eff});
    assign group_end = row_end || (col_reg[POS_W-1:0] == '1);
    assign pad       = ~col_reg[POS_W-1:0];

    // A group end needs the emitter free to take the finished words.
    assign pixels.ready = !group_end || load_ok;
    assign accept       = pixels.valid && pixels.ready;

    // Shift the pixel's bits in; planes at or above the count take zero.
    always_comb
    begin
        for (int p = 0; p < MAX_PLANES; p++)
        begin
            shift_next[p] = {shift_reg[p][WORD_BITS-2:0],
                             (PCNT_W'(p) < planes_eff) && pixels.pixel[p]};
            grp.words[p]  = shift_next[p] << pad;
        end
        grp.valid     = accept && group_end;
        grp.planes    = planes_eff;
        grp.image_end = img_end;
    end

    // Plane registers and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else if (accept)
        begin
            shift_reg <= group_end ? '0 : shift_next;
            if (row_end)
            begin
                col_reg <= '0;
                row_reg <= img_end ? '0 : row_reg + DIM_W'(1);
            end
            else
            begin
                col_reg <= col_reg + DIM_W'(1);
            end
        end
    end

endmodule

### hdl/ibwp_emit.sv
// ----------------------------------------------------------------------------
// Word emitter
// Holds one finished group and sends its plane words one per handshake,
// plane 0 first, marking the group's and the image's last word.
// ----------------------------------------------------------------------------
module ibwp_emit
    import ibwp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  grp_load_t         grp,
    output logic              load_ok,
    ibwp_word_if.source       words
);

    plane_words_t      words_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [PCNT_W-1:0] planes_reg;
    logic              img_reg;
    logic              busy_reg;
    logic              last_word;
    logic              take;

    assign last_word = (PCNT_W'(idx_reg) + PCNT_W'(1)) == planes_reg;
    assign take      = busy_reg && words.ready;

    // Free now, or freeing as the last word of the group leaves.
    assign load_ok = !busy_reg || (take && last_word);

    // Output side of the channel.
    assign words.valid       = busy_reg;
    assign words.plane_word  = words_reg[0];
    assign words.plane_index = idx_reg;
    assign words.group_last  = last_word;
    assign words.image_last  = last_word && img_reg;

    // Control: busy flag and plane index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (grp.valid)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (take)
        begin
            busy_reg <= !last_word;
            idx_reg  <= idx_reg + IDX_W'(1);
        end
    end

    // Payload: group words move down one place per word sent.
    always_ff @(posedge clk)
    begin
        if (grp.valid)
        begin
            words_reg  <= grp.words;
            planes_reg <= grp.planes;
            img_reg    <= grp.image_end;
        end
        else if (take)
        begin
            for (int p = 0; p < MAX_PLANES - 1; p++)
            begin
                words_reg[p] <= words_reg[p+1];
            end
            words_reg[MAX_PLANES-1] <= '0;
        end
    end

endmodule

### hdl/interleaved_bitplane_word_packer.sv
// ----------------------------------------------------------------------------
// Interleaved bitplane word packer
// Converts chunky pixels to word-interleaved 16-bit bitplanes.
// ----------------------------------------------------------------------------
// Pixels are taken one per cycle in raster order. Every 16th pixel of a row,
// and the last pixel of a row, closes a group; the group's plane words (one
// per plane, plane 0 first, right-padded with zeros) then leave the emitter one
// per cycle while the words are taken; it holds one group while the next
// gathers. A group-closing pixel is taken only when the emitter is empty or
// sending its last word, so with the word channel ready the sustained rate
// is one pixel per cycle while groups hold at least as many pixels as there
// are planes. Configuration writes take effect on the next pixel and should
// be made only while the block is idle.
// ----------------------------------------------------------------------------
module interleaved_bitplane_word_packer
    import ibwp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    ibwp_pixel_if.sink            pixels,
    ibwp_word_if.source           words
);

    cfg_t      cfg_reg;
    grp_load_t grp;
    logic      load_ok;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= RST_IMAGE_WIDTH;
            cfg_reg.image_height <= RST_IMAGE_HEIGHT;
            cfg_reg.plane_count  <= RST_PLANE_COUNT;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  cfg_reg.image_width  <= cfg_data;
                REG_IMAGE_HEIGHT: cfg_reg.image_height <= cfg_data;
                REG_PLANE_COUNT:  cfg_reg.plane_count  <= cfg_data[PCNT_W-1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Pixel gatherer.
    ibwp_gather u_gather (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .pixels  (pixels),
        .load_ok (load_ok),
        .grp     (grp)
    );

    // Word emitter.
    ibwp_emit u_emit (
        .clk     (clk),
        .rst_n   (rst_n),
        .grp     (grp),
        .load_ok (load_ok),
        .words   (words)
    );

endmodule

### hdl/ibwp_checker.sv
// ----------------------------------------------------------------------------
// Interleaved bitplane word packer: port checker
// Watches the word channel for ordering and marker consistency.
// ----------------------------------------------------------------------------
module ibwp_checker
    import ibwp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             out_valid,
    input  logic             out_ready,
    input  logic [IDX_W-1:0] plane_index,
    input  logic             group_last,
    input  logic             image_last
);

    // A pending word is not withdrawn.
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("word withdrawn before it was taken");

    // Within a group the next plane follows at once.
    a_plane_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !group_last |=>
            out_valid && (plane_index == $past(plane_index) + IDX_W'(1)))
        else $error("plane words of a group out of sequence");

    // The image's last word also closes a group.
    a_image_group: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && image_last |-> group_last)
        else $error("image end marked inside a group");

    // The highest plane is always the last of its group.
    a_top_plane: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (plane_index == IDX_W'(MAX_PLANES - 1)) |-> group_last)
        else $error("group runs past the highest plane");

endmodule

bind interleaved_bitplane_word_packer ibwp_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (words.valid),
    .out_ready   (words.ready),
    .plane_index (words.plane_index),
    .group_last  (words.group_last),
    .image_last  (words.image_last)
);
